/* src/scalar_serializer_varint_zigzag_core_macros.svh */
// assertion helpers shared by the serializer rtl
`ifndef SCALAR_SERIALIZER_VARINT_ZIGZAG_CORE_MACROS_SVH
`define SCALAR_SERIALIZER_VARINT_ZIGZAG_CORE_MACROS_SVH

// consequent checked in the same cycle
`define SSVZ_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the next cycle
`define SSVZ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/ssvz_pkg.sv */
package ssvz_pkg;

	localparam int unsigned ValueWidth = 64;
	localparam int unsigned CmdWidth   = 3;
	localparam int unsigned ByteWidth  = 8;
	localparam int unsigned GroupBits  = 7;
	localparam int unsigned MaxGroups  = 8;
	localparam int unsigned CountWidth = 4;

	localparam logic [ByteWidth-1:0] ContBit = 8'h80;

	typedef enum logic [CmdWidth-1:0] {
		CMD_FIXED1  = 3'd0,
		CMD_FIXED4  = 3'd1,
		CMD_FIXED8  = 3'd2,
		CMD_VAR_U32 = 3'd3,
		CMD_VAR_S32 = 3'd4,
		CMD_VAR_U64 = 3'd5,
		CMD_VAR_S64 = 3'd6
	} cmd_t;

	// what the shifter starts from for one item
	typedef struct packed {
		logic                  valid;
		logic                  fixed;
		logic [2:0]            last_idx;
		logic [ValueWidth-1:0] value;
	} load_t;

	typedef struct packed {
		logic load;
		logic advance;
	} ctrl_t;

	typedef struct packed {
		logic [ByteWidth-1:0] data;
		logic                 last;
	} stat_t;

endpackage

/* src/ssvz_map.sv */
module ssvz_map (
	input  logic [ssvz_pkg::CmdWidth-1:0]   command,
	input  logic [ssvz_pkg::ValueWidth-1:0] value,
	output ssvz_pkg::load_t                 ld
);

	logic [31:0] lo;

	assign lo = value[31:0];

	always_comb begin
		ld.valid    = 1'b1;
		ld.fixed    = 1'b0;
		ld.last_idx = 3'd0;
		ld.value    = value;
		case (command)
			ssvz_pkg::CMD_FIXED1: begin
				ld.fixed    = 1'b1;
				ld.last_idx = 3'd0;
			end
			ssvz_pkg::CMD_FIXED4: begin
				ld.fixed    = 1'b1;
				ld.last_idx = 3'd3;
			end
			ssvz_pkg::CMD_FIXED8: begin
				ld.fixed    = 1'b1;
				ld.last_idx = 3'd7;
			end
			ssvz_pkg::CMD_VAR_U32: begin
				ld.value = {32'd0, lo};
			end
			ssvz_pkg::CMD_VAR_S32: begin
				// zigzag at 32 bits
				ld.value = {32'd0, {lo[30:0], 1'b0} ^ {32{lo[31]}}};
			end
			ssvz_pkg::CMD_VAR_U64: begin
				ld.value = value;
			end
			ssvz_pkg::CMD_VAR_S64: begin
				ld.value = {value[62:0], 1'b0} ^ {64{value[63]}};
			end
			default: begin
				ld.valid = 1'b0;
			end
		endcase
	end

endmodule

/* src/ssvz_shifter.sv */
module ssvz_shifter (
	input  logic            clk,
	input  logic            arst_n,
	input  ssvz_pkg::ctrl_t ctrl,
	input  ssvz_pkg::load_t ld,
	output ssvz_pkg::stat_t stat
);

	logic [ssvz_pkg::ValueWidth-1:0] value_q;
	logic [ssvz_pkg::CountWidth-1:0] count_q;
	logic                            fixed_q;
	logic [2:0]                      last_idx_q;
	logic                            more;
	logic                            ninth;

	// anything left above the low group
	assign more  = |value_q[ssvz_pkg::ValueWidth-1:ssvz_pkg::GroupBits];
	assign ninth = (count_q == ssvz_pkg::CountWidth'(ssvz_pkg::MaxGroups));

	always_comb begin
		if (fixed_q) begin
			stat.data = value_q[ssvz_pkg::ByteWidth-1:0];
			stat.last = (count_q[2:0] == last_idx_q);
		end else if (ninth) begin
			// remaining 8 bits go out whole
			stat.data = value_q[ssvz_pkg::ByteWidth-1:0];
			stat.last = 1'b1;
		end else if (more) begin
			stat.data = ssvz_pkg::ContBit | {1'b0, value_q[ssvz_pkg::GroupBits-1:0]};
			stat.last = 1'b0;
		end else begin
			stat.data = {1'b0, value_q[ssvz_pkg::GroupBits-1:0]};
			stat.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			fixed_q    <= 1'b0;
			last_idx_q <= 3'd0;
		end else if (ctrl.load) begin
			count_q    <= '0;
			fixed_q    <= ld.fixed;
			last_idx_q <= ld.last_idx;
		end else if (ctrl.advance && !stat.last) begin
			count_q <= count_q + 1'b1;
		end
	end

	// one shared shifter, 8 bits a step for fixed, 7 for varint groups
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			value_q <= ld.value;
		end else if (ctrl.advance) begin
			value_q <= fixed_q ? (value_q >> ssvz_pkg::ByteWidth)
			                   : (value_q >> ssvz_pkg::GroupBits);
		end
	end

endmodule

/* src/scalar_serializer_varint_zigzag_core.sv */
// an accepted value is loaded into the shifter, then its first byte into the output register
// each value gives n = 1..9 bytes from the single shifter, one byte per cycle while the output
// register is free to take it
// input is taken again the cycle after the final byte is registered
// reset: arst_n low clears the sequencer and output valid asynchronously
`include "scalar_serializer_varint_zigzag_core_macros.svh"

module scalar_serializer_varint_zigzag_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // [63:0] value
	input  logic [2:0]  s_axis_tuser,   // [2:0] command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
	output logic        m_axis_tlast
);

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	state_t           state_q;
	logic             m_valid_q;
	logic [7:0]       m_data_q;
	logic             m_last_q;
	logic             in_xfer;
	logic             go;
	ssvz_pkg::load_t  ld;
	ssvz_pkg::ctrl_t  ctrl;
	ssvz_pkg::stat_t  stat;

	// the map turns the command into start value and byte-count rules
	ssvz_map u_map (
		.command (s_axis_tuser),
		.value   (s_axis_tdata),
		.ld      (ld)
	);

	// shared shift unit plus group counter
	ssvz_shifter u_shifter (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.ld     (ld),
		.stat   (stat)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	// while emitting, a byte moves into the output register whenever that register is free
	assign go = (state_q == ST_EMIT) && (!m_valid_q || m_axis_tready);

	assign ctrl.load    = in_xfer;
	assign ctrl.advance = go;

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
			m_last_q  <= 1'b0;
		end else begin
			// output register drains on a transfer unless refilled below
			if (m_axis_tready && !go) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					// unused command is swallowed with no output
					if (in_xfer && ld.valid) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (go) begin
						m_valid_q <= 1'b1;
						m_data_q  <= stat.data;
						m_last_q  <= stat.last;
						if (stat.last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`SSVZ_ASSERT_NEXT(a_start_emit, in_xfer && ld.valid, state_q == ST_EMIT,
		"valid command did not start emission")
	`SSVZ_ASSERT_NEXT(a_drop_unused, in_xfer && !ld.valid, state_q == ST_IDLE,
		"unused command started emission")
	`SSVZ_ASSERT_NEXT(a_go_fills, go, m_valid_q && m_last_q == $past(stat.last),
		"emitted byte not registered")
	`SSVZ_ASSERT_SAME(a_busy_no_take, state_q == ST_EMIT, !in_xfer,
		"input taken while emitting")

endmodule

/* tb/tb_scalar_serializer_varint_zigzag_core.sv */
`timescale 1ns / 1ps

module tb_scalar_serializer_varint_zigzag_core;

	// command code outside the encoding set, the block drops it
	localparam logic [ssvz_pkg::CmdWidth-1:0] CmdUnused = 3'd7;

	// generous bound on the whole run, in clock cycles
	localparam int unsigned CycleLimit = 400000;
	// cycles allowed after the last byte before the verdict
	localparam int unsigned DrainCycles = 20;
	// mismatches printed in full, later ones only counted
	localparam int unsigned ReportLimit = 10;

	// one serialized byte as it should leave the block
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} ser_byte_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;   // [63:0] value
	logic [2:0]  s_axis_tuser;   // [2:0] command
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;   // [7:0] out_byte
	logic        m_axis_tlast;

	// bytes still owed by the block, oldest first
	ser_byte_t   expected_bytes[$];
	ser_byte_t   head_byte;

	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;

	// chance in a hundred that the sender idles or the receiver stalls
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;

	scalar_serializer_varint_zigzag_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// appends one byte to the tail of the expected stream
	function automatic void queue_byte(input logic [7:0] data, input logic last);
		ser_byte_t entry;
		entry.data = data;
		entry.last = last;
		expected_bytes.insert(expected_bytes.size(), entry);
	endfunction

	// computes the byte stream for one value and queues it
	function automatic void predict_encoding(input logic [ssvz_pkg::CmdWidth-1:0] cmd,
	                                         input logic [63:0] value);
		logic [63:0] group_src;
		logic [31:0] narrow;
		int          fixed_len;
		int          groups;
		bit          done;
		group_src = '0;
		narrow    = '0;
		fixed_len = 0;
		done      = 1'b0;
		case (cmd)
			ssvz_pkg::CMD_FIXED1:  fixed_len = 1;
			ssvz_pkg::CMD_FIXED4:  fixed_len = 4;
			ssvz_pkg::CMD_FIXED8:  fixed_len = 8;
			ssvz_pkg::CMD_VAR_U32: group_src = {32'd0, value[31:0]};
			ssvz_pkg::CMD_VAR_S32: begin
				// zigzag at 32 bits, upper half of value ignored
				narrow    = value[31:0];
				group_src = {32'd0, (narrow << 1) ^ {32{narrow[31]}}};
			end
			ssvz_pkg::CMD_VAR_U64: group_src = value;
			ssvz_pkg::CMD_VAR_S64: group_src = (value << 1) ^ {64{value[63]}};
			default:               return;
		endcase
		if (fixed_len != 0) begin
			// raw bits, little-endian
			for (int i = 0; i < fixed_len; i++)
				queue_byte(value[8*i +: 8], (i == fixed_len - 1));
			return;
		end
		// 7-bit groups low first; after eight groups the ninth byte is whole
		for (groups = 0; !done; groups++) begin
			if (groups == ssvz_pkg::MaxGroups) begin
				queue_byte(group_src[7:0], 1'b1);
				done = 1'b1;
			end else if (group_src >= 64'(ssvz_pkg::ContBit)) begin
				queue_byte(ssvz_pkg::ContBit | {1'b0, group_src[6:0]}, 1'b0);
				group_src = group_src >> ssvz_pkg::GroupBits;
			end else begin
				queue_byte({1'b0, group_src[6:0]}, 1'b1);
				done = 1'b1;
			end
		end
	endfunction

	// checks every output transfer against the oldest expected byte
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_bytes.size() == 0) begin
				if (mismatch_count < ReportLimit)
					$display("unexpected byte: data %h last %b", m_axis_tdata, m_axis_tlast);
				mismatch_count++;
			end else begin
				head_byte = expected_bytes.pop_front();
				if (m_axis_tdata !== head_byte.data || m_axis_tlast !== head_byte.last) begin
					if (mismatch_count < ReportLimit)
						$display("byte mismatch: expected data %h last %b, got data %h last %b",
						         head_byte.data, head_byte.last, m_axis_tdata, m_axis_tlast);
					mismatch_count++;
				end
			end
		end
	end

	// offers one value, waits for its transfer, then queues its bytes
	task automatic send_scalar(input logic [ssvz_pkg::CmdWidth-1:0] cmd,
	                           input logic [63:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		s_axis_tuser  <= cmd;
		do @(posedge clk); while (!s_axis_tready);
		predict_encoding(cmd, value);
	endtask

	// fixed widths: narrow kinds must drop the upper bits
	task automatic test_fixed_widths();
		send_scalar(ssvz_pkg::CMD_FIXED1, 64'h0);
		send_scalar(ssvz_pkg::CMD_FIXED1, 64'hA5A5_A5A5_A5A5_A5FF);
		send_scalar(ssvz_pkg::CMD_FIXED4, 64'h0123_4567_89AB_CDEF);
		send_scalar(ssvz_pkg::CMD_FIXED4, 64'hFFFF_FFFF_0000_0000);
		send_scalar(ssvz_pkg::CMD_FIXED8, 64'hFFFF_FFFF_FFFF_FFFF);
		send_scalar(ssvz_pkg::CMD_FIXED8, 64'h0123_4567_89AB_CDEF);
	endtask

	// varint group boundaries, zigzag sign cases and the whole ninth byte
	task automatic test_varint_boundaries();
		send_scalar(ssvz_pkg::CMD_VAR_U32, 64'h0);
		send_scalar(ssvz_pkg::CMD_VAR_U32, 64'h7F);
		send_scalar(ssvz_pkg::CMD_VAR_U32, 64'h80);
		send_scalar(ssvz_pkg::CMD_VAR_U32, 64'hDEAD_BEEF_FFFF_FFFF);
		send_scalar(ssvz_pkg::CMD_VAR_S32, 64'h0);
		send_scalar(ssvz_pkg::CMD_VAR_S32, 64'h0000_0000_FFFF_FFFF);
		send_scalar(ssvz_pkg::CMD_VAR_S32, 64'hFFFF_FFFF_7FFF_FFFF);
		send_scalar(ssvz_pkg::CMD_VAR_S32, 64'h0000_0000_8000_0000);
		send_scalar(ssvz_pkg::CMD_VAR_U64, 64'h00FF_FFFF_FFFF_FFFF);
		send_scalar(ssvz_pkg::CMD_VAR_U64, 64'h0100_0000_0000_0000);
		send_scalar(ssvz_pkg::CMD_VAR_U64, 64'hFFFF_FFFF_FFFF_FFFF);
		send_scalar(ssvz_pkg::CMD_VAR_S64, 64'hFFFF_FFFF_FFFF_FFFF);
		send_scalar(ssvz_pkg::CMD_VAR_S64, 64'h8000_0000_0000_0000);
		send_scalar(ssvz_pkg::CMD_VAR_S64, 64'h7FFF_FFFF_FFFF_FFFF);
	endtask

	// the spare command code must produce no bytes
	task automatic test_unused_command();
		send_scalar(CmdUnused, {$urandom, $urandom});
		send_scalar(ssvz_pkg::CMD_FIXED1, 64'h5A);
		send_scalar(CmdUnused, 64'hFFFF_FFFF_FFFF_FFFF);
		send_scalar(ssvz_pkg::CMD_VAR_U32, 64'h3FFF);
	endtask

	// random commands and values under one idling pattern
	task automatic test_random_traffic(input int unsigned count,
	                                   input int unsigned idle_pct,
	                                   input int unsigned stall_pct);
		int unsigned                   encoded;
		logic [ssvz_pkg::CmdWidth-1:0] cmd;
		logic [63:0]                   value;
		logic [63:0]                   width_mask;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		encoded = 0;
		while (encoded < count) begin
			// the spare code shows up now and then, it does not count
			cmd        = ($urandom_range(15) == 0) ? CmdUnused
			                                       : ssvz_pkg::CmdWidth'($urandom_range(6));
			value      = {$urandom, $urandom};
			width_mask = (64'd1 << $urandom_range(63)) - 64'd1;
			// spread values over every encoded length
			case ($urandom_range(3))
				0: value = value;
				1: value = value & width_mask;
				2: value = ~(value & width_mask);
				default: begin
					case ($urandom_range(7))
						0: value = 64'h0;
						1: value = 64'h7F;
						2: value = 64'h0000_0000_7FFF_FFFF;
						3: value = 64'h0000_0000_8000_0000;
						4: value = 64'h00FF_FFFF_FFFF_FFFF;
						5: value = 64'h0100_0000_0000_0000;
						6: value = 64'h8000_0000_0000_0000;
						default: value = 64'hFFFF_FFFF_FFFF_FFFF;
					endcase
				end
			endcase
			send_scalar(cmd, value);
			if (cmd != CmdUnused)
				encoded++;
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		s_axis_tuser   = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fixed_widths();
		test_varint_boundaries();
		test_unused_command();
		test_random_traffic(38, 0, 0);
		test_random_traffic(38, 77, 0);
		test_random_traffic(38, 0, 77);
		test_random_traffic(38, 16, 16);

		s_axis_tvalid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		// let any stray byte show up before the verdict
		repeat (DrainCycles) @(posedge clk);

		if (mismatch_count == 0 && expected_bytes.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
